// ----- rtl/core/dqr_pkg.sv -----
// Shared types and constants for the double-ended queue with remove.
`default_nettype none

package dqr_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/dqr_mem.sv -----
// Single-write, single-read entry store with registered read data.
`default_nettype none

module dqr_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [IW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] entry_mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= entry_mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/dqr_ring_addr.sv -----
// Shared ring adder: maps a queue position to its store slot.
`default_nettype none

module dqr_ring_addr #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  wire logic [IW-1:0] front_i,
  input  wire logic [IW-1:0] pos_i,
  output logic      [IW-1:0] slot_o
);

  localparam logic [IW:0] DepthC = (IW+1)'(DEPTH);

  logic [IW:0] sum;

  always_comb begin
    sum = {1'b0, front_i} + {1'b0, pos_i};
    if (sum >= DepthC) begin
      sum = sum - DepthC;
    end
    slot_o = sum[IW-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dqr_seq.sv -----
// Sequencer: ring pointers, action state machine and result registers.
`default_nettype none

module dqr_seq #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned IW         = $clog2(DEPTH),
  localparam int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [dqr_pkg::ACTION_W-1:0]         action_i,
  input  wire logic [dqr_pkg::VALUE_W-1:0]          value_i,
  output logic                                      done_o,
  output logic      [dqr_pkg::VALUE_W-1:0]          result_value_o,
  output logic      [dqr_pkg::STATUS_W-1:0]         status_o,
  output logic      [dqr_pkg::FILL_W-1:0]           fill_count_o,
  output logic                                      is_empty_o,
  output logic                                      mem_we_o,
  output logic      [IW-1:0]                        mem_addr_o,
  output logic      [VALUE_WIDTH-1:0]               mem_wdata_o,
  input  wire logic [VALUE_WIDTH-1:0]               mem_rdata_i
);

  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  dqr_pkg::state_e  state_q, state_d;
  dqr_pkg::action_e act_q, act_d;
  logic [VALUE_WIDTH-1:0] word_q, word_d;
  logic [IW-1:0]          front_q, front_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          p_q, p_d;

  logic                       done_q, done_d;
  logic [VALUE_WIDTH-1:0]     res_q, res_d;
  dqr_pkg::status_e           status_q, status_d;
  logic [dqr_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                       empty_q, empty_d;

  logic [IW-1:0] pos;
  logic [IW-1:0] slot;
  logic [CW-1:0] p_inc;
  logic          finish;

  dqr_ring_addr #(
    .DEPTH (DEPTH)
  ) u_ring_addr (
    .front_i (front_q),
    .pos_i   (pos),
    .slot_o  (slot)
  );

  assign p_inc = CW'(p_q) + CW'(1);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    word_d      = word_q;
    front_d     = front_q;
    count_d     = count_q;
    p_d         = p_q;
    pos         = '0;
    mem_we_o    = 1'b0;
    mem_wdata_o = word_q;
    finish      = 1'b0;
    res_d       = '0;
    status_d    = dqr_pkg::STATUS_OK;

    case (state_q)
      dqr_pkg::S_IDLE: begin
        if (start) begin
          act_d   = dqr_pkg::action_e'(action_i);
          word_d  = VALUE_WIDTH'(value_i);
          state_d = dqr_pkg::S_EXEC;
        end
      end
      dqr_pkg::S_EXEC: begin
        case (act_q)
          dqr_pkg::ACT_PUSH_BACK: begin
            if (count_q == DepthC) begin
              status_d = dqr_pkg::STATUS_FULL;
            end else begin
              pos      = IW'(count_q);
              mem_we_o = 1'b1;
              count_d  = count_q + CW'(1);
            end
            finish = 1'b1;
          end
          dqr_pkg::ACT_PUSH_FRONT: begin
            if (count_q == DepthC) begin
              status_d = dqr_pkg::STATUS_FULL;
            end else begin
              pos      = IW'(DEPTH - 1);
              mem_we_o = 1'b1;
              front_d  = slot;
              count_d  = count_q + CW'(1);
            end
            finish = 1'b1;
          end
          dqr_pkg::ACT_POP_BACK: begin
            if (count_q == '0) begin
              status_d = dqr_pkg::STATUS_EMPTY;
              finish   = 1'b1;
            end else begin
              pos     = IW'(count_q - CW'(1));
              state_d = dqr_pkg::S_POP_WAIT;
            end
          end
          dqr_pkg::ACT_POP_FRONT: begin
            if (count_q == '0) begin
              status_d = dqr_pkg::STATUS_EMPTY;
              finish   = 1'b1;
            end else begin
              pos     = '0;
              state_d = dqr_pkg::S_POP_WAIT;
            end
          end
          dqr_pkg::ACT_REMOVE: begin
            if (count_q == '0) begin
              status_d = dqr_pkg::STATUS_EMPTY;
              finish   = 1'b1;
            end else begin
              p_d     = IW'(count_q - CW'(1));
              state_d = dqr_pkg::S_SRCH_RD;
            end
          end
          dqr_pkg::ACT_CLEAR: begin
            count_d = '0;
            front_d = '0;
            finish  = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      dqr_pkg::S_POP_WAIT: begin
        res_d   = mem_rdata_i;
        count_d = count_q - CW'(1);
        if (act_q == dqr_pkg::ACT_POP_FRONT) begin
          pos     = IW'(1);
          front_d = slot;
        end
        finish = 1'b1;
      end
      dqr_pkg::S_SRCH_RD: begin
        pos     = p_q;
        state_d = dqr_pkg::S_SRCH_CMP;
      end
      dqr_pkg::S_SRCH_CMP: begin
        if (mem_rdata_i == word_q) begin
          state_d = dqr_pkg::S_SHIFT_RD;
        end else if (p_q == '0) begin
          status_d = dqr_pkg::STATUS_NOT_FOUND;
          finish   = 1'b1;
        end else begin
          p_d     = p_q - IW'(1);
          state_d = dqr_pkg::S_SRCH_RD;
        end
      end
      dqr_pkg::S_SHIFT_RD: begin
        if (p_inc < count_q) begin
          pos     = IW'(p_inc);
          state_d = dqr_pkg::S_SHIFT_WR;
        end else begin
          count_d = count_q - CW'(1);
          res_d   = word_q;
          finish  = 1'b1;
        end
      end
      dqr_pkg::S_SHIFT_WR: begin
        pos         = p_q;
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        p_d         = IW'(p_inc);
        state_d     = dqr_pkg::S_SHIFT_RD;
      end
      default: begin
        state_d = dqr_pkg::S_IDLE;
      end
    endcase

    if (finish) begin
      state_d = dqr_pkg::S_IDLE;
    end
    done_d  = finish;
    fill_d  = dqr_pkg::FILL_W'(count_d);
    empty_d = (count_d == '0);
  end

  assign mem_addr_o = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqr_pkg::S_IDLE;
      front_q <= '0;
      count_q <= '0;
      p_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      p_q     <= p_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    word_q <= word_d;
    if (finish) begin
      res_q    <= res_d;
      status_q <= status_d;
      fill_q   <= fill_d;
      empty_q  <= empty_d;
    end
  end

  assign busy           = (state_q != dqr_pkg::S_IDLE);
  assign done_o         = done_q;
  assign result_value_o = dqr_pkg::VALUE_W'(res_q);
  assign status_o       = status_q;
  assign fill_count_o   = fill_q;
  assign is_empty_o     = empty_q;

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue_with_remove.sv -----
// Top level of the bounded double-ended queue with remove by value.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      action_i, value_i
// result    out        done_o strobe, one cycle  result_value_o, status_o,
//                                                fill_count_o, is_empty_o
//
// Push, clear, unknown actions and any pop or remove on an empty queue end in S_EXEC.
// Other pops go on to S_POP_WAIT, set by the registered RAM read.
// Remove compares entries from the back toward the front; on a match it shifts each
// later entry forward one place. Reads and writes take separate states, set by the
// single RAM port and shared ring adder; a request is taken while done_o is high.
// Reset clears the pointers and the count, not the store; the receiver cannot stall.
`default_nettype none

module double_ended_queue_with_remove #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [dqr_pkg::ACTION_W-1:0] action_i,
  input  wire logic [dqr_pkg::VALUE_W-1:0]  value_i,
  output logic                              done_o,
  output logic      [dqr_pkg::VALUE_W-1:0]  result_value_o,
  output logic      [dqr_pkg::STATUS_W-1:0] status_o,
  output logic      [dqr_pkg::FILL_W-1:0]   fill_count_o,
  output logic                              is_empty_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                   mem_we;
  logic [IW-1:0]          mem_addr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  dqr_seq #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .fill_count_o   (fill_count_o),
    .is_empty_o     (is_empty_o),
    .mem_we_o       (mem_we),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata)
  );

  dqr_mem #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (mem_addr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_addr),
    .rd_data_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dqr_checker.sv -----
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none

module dqr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done_o,
  input wire logic [dqr_pkg::STATUS_W-1:0] status_o,
  input wire logic [dqr_pkg::FILL_W-1:0]   fill_count_o,
  input wire logic                         is_empty_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (fill_count_o == '0))
    else $error("empty flag with nonzero fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == dqr_pkg::STATUS_EMPTY)) |-> is_empty_o)
    else $error("empty status on a queue that holds entries");

endmodule

bind double_ended_queue_with_remove dqr_checker u_dqr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .fill_count_o (fill_count_o),
  .is_empty_o   (is_empty_o)
);

`default_nettype wire
